// File: src/ptg_pkg.sv
// ----------------------------------------------------------------------------
// ptg_pkg: shared types and constants of the polynomial table generator
// Sizes, command codes and the row record handed down the Horner cell chain.
// ----------------------------------------------------------------------------
package ptg_pkg;

  localparam int unsigned MaxDegree = 7;
  localparam int unsigned NumCoeff  = MaxDegree + 1;
  localparam int unsigned MaxSteps  = 63;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned CntW      = 6;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdGen  = 1'b1;

  // Record that moves from one Horner cell to the next
  typedef struct packed {
    logic               vld;
    logic signed [31:0] x;
    logic signed [63:0] acc;
    logic               ovf;
    logic               last;
  } row_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StGen  = 4'b0100,
    StWait = 4'b1000
  } state_e;

  // Saturating add of two 64-bit values; flags saturation
  function automatic logic [64:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      return {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
    end else if (s < -65'sh0_8000_0000_0000_0000) begin
      return {1'b1, 64'h8000_0000_0000_0000};
    end
    return {1'b0, s[63:0]};
  endfunction

endpackage

// File: src/ptg_div.sv
// ----------------------------------------------------------------------------
// ptg_div: step divider
// Restoring division of the 33-bit span by the step count, one bit a cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ptg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [32:0]  span_i,
  input  logic [5:0]          den_i,
  output logic                done_o,
  output logic signed [32:0]  quot_o
);

  logic [32:0] rem_q, rem_d, quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [5:0]  den_q, den_d;
  logic [33:0] trial;

  // Shift one numerator bit per cycle into the remainder
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    den_d  = den_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[32]} - {28'd0, den_q};
    if (start_i) begin
      neg_d  = span_i[32];
      quo_d  = span_i[32] ? 33'(-span_i) : 33'(span_i);
      rem_d  = '0;
      cnt_d  = 6'd33;
      den_d  = den_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[32]};
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 33'(-$signed(quo_q)) : $signed(quo_q);

endmodule

// File: src/ptg_cell.sv
// ----------------------------------------------------------------------------
// ptg_cell: one Horner cell
// Adds its coefficient, then multiplies by the point (floor shift by 16,
// saturate) over three registered steps; bypasses when above the degree.
// ----------------------------------------------------------------------------
module ptg_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                use_i,
  input  logic signed [15:0]  coeff_i,
  input  ptg_pkg::row_t       row_i,
  output ptg_pkg::row_t       row_o
);

  ptg_pkg::row_t     s1_q, s2_q, s3_q;
  logic [64:0]       add_r;
  logic              neg_s1;
  logic [63:0]       ma;
  logic [31:0]       mx;
  logic [63:0]       plo_q, phi_q;
  logic              neg_q, use1_q, use2_q, use3_q;
  logic [95:0]       prod;
  logic [79:0]       q;
  logic              sat;
  logic signed [63:0] mres;

  // Add coefficient with saturation
  assign add_r = ptg_pkg::sat_add(row_i.acc, 64'(coeff_i) <<< 16);

  // Stage 1: add; stage 2: two 32x32 partial products; stage 3: combine
  assign neg_s1 = s1_q.acc[63] ^ s1_q.x[31];
  assign ma = s1_q.acc[63] ? 64'(-s1_q.acc) : 64'(s1_q.acc);
  assign mx = s1_q.x[31] ? 32'(-s1_q.x) : 32'(s1_q.x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q.vld  <= row_i.vld;
      s1_q.x    <= row_i.x;
      s1_q.last <= row_i.last;
      if (use_i) begin
        s1_q.acc <= $signed(add_r[63:0]);
        s1_q.ovf <= row_i.ovf | add_r[64];
      end else begin
        s1_q.acc <= row_i.acc;
        s1_q.ovf <= row_i.ovf;
      end
      s2_q      <= s1_q;
      s3_q.vld  <= s2_q.vld;
      s3_q.x    <= s2_q.x;
      s3_q.last <= s2_q.last;
      if (use2_q) begin
        s3_q.acc <= mres;
        s3_q.ovf <= s2_q.ovf | sat;
      end else begin
        s3_q.acc <= s2_q.acc;
        s3_q.ovf <= s2_q.ovf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    use1_q <= use_i;
    use2_q <= use1_q;
    use3_q <= use2_q;
    plo_q  <= {32'd0, ma[31:0]} * {32'd0, mx};
    phi_q  <= {32'd0, ma[63:32]} * {32'd0, mx};
    neg_q  <= neg_s1;
  end

  // Floor shift of the signed product, then saturate to 64 bits
  always_comb begin
    prod = {phi_q, 32'd0} + {32'd0, plo_q};
    q    = prod[95:16];
    if (neg_q && prod[15:0] != 16'd0) q = q + 80'd1;
    sat  = 1'b0;
    if (!neg_q) begin
      if (q > 80'h7FFF_FFFF_FFFF_FFFF) begin
        sat = 1'b1; mres = 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
        mres = $signed(q[63:0]);
      end
    end else begin
      if (q > 80'h8000_0000_0000_0000) begin
        sat = 1'b1; mres = 64'sh8000_0000_0000_0000;
      end else begin
        mres = $signed(64'(-q[63:0]));
      end
    end
  end

  assign row_o = s3_q;

endmodule

// File: src/polynomial_table_generator.sv
// ----------------------------------------------------------------------------
// polynomial_table_generator: Horner value table over a Q16.16 interval
// Loads coefficients, divides the interval into steps and streams one row
// per point through a chain of seven Horner cells and a final adder.
// ----------------------------------------------------------------------------
// channel  dir  beat
// s_axis   in   command, coeff_index, coeff_value, start_x, stop_x, step_count
// m_axis   out  sample_x, poly_value, overflow; tlast = last row
// cfg      in   degree (3 bits)
// A load writes one coefficient register. A table first divides the interval into steps
// (no division when step_count is 0), then one row enters the cell chain per cycle
// while issue is not stalled; each row passes the seven cells and the final adder.
// Row issue stalls while the row FIFO (32 deep) lacks room for in-flight rows.
// Reset clears coefficients to zero and sets degree to 1.
// ----------------------------------------------------------------------------
module polynomial_table_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [0] command [3:1] coeff_index [19:4] coeff_value [51:20] start_x
  // [83:52] stop_x [89:84] step_count
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] sample_x [95:32] poly_value [96] overflow
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_wdata_i
);

  localparam int unsigned NCell = ptg_pkg::MaxDegree;

  ptg_pkg::state_e    st_q, st_d;
  logic signed [15:0] coef_q [ptg_pkg::NumCoeff];
  logic [2:0]         deg_q;
  logic signed [31:0] x_q;
  logic [5:0]         cnt_q, j_q;
  logic signed [31:0] step_q;
  logic               div_done;
  logic signed [32:0] quot;
  logic               issue;
  logic [5:0]         inflight_q;
  logic [5:0]         fcount_q;
  ptg_pkg::row_t      rows [NCell+1];
  ptg_pkg::row_t      fin;
  logic [64:0]        fadd;
  logic [97:0]        fifo_q [32];
  logic [4:0]         wp_q, rp_q;
  logic               fwr, frd;
  logic               acc_in;
  logic               cmd;

  assign cmd    = s_axis_tdata[0];
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ptg_pkg::StIdle);

  ptg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_in && cmd == ptg_pkg::CmdGen && s_axis_tdata[89:84] != 6'd0),
    .span_i  (33'($signed(s_axis_tdata[83:52])) - 33'($signed(s_axis_tdata[51:20]))),
    .den_i   (s_axis_tdata[89:84]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Issue a row when the FIFO has room for every row in flight
  assign issue = (st_q == ptg_pkg::StGen) && (fcount_q + inflight_q < 6'd32);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ptg_pkg::StIdle: begin
        if (acc_in && cmd == ptg_pkg::CmdGen) begin
          st_d = (s_axis_tdata[89:84] == 6'd0) ? ptg_pkg::StGen : ptg_pkg::StDiv;
        end
      end
      ptg_pkg::StDiv:  if (div_done) st_d = ptg_pkg::StGen;
      ptg_pkg::StGen:  if (issue && j_q == cnt_q) st_d = ptg_pkg::StWait;
      ptg_pkg::StWait: if (inflight_q == 6'd0 && fcount_q == 6'd0) st_d = ptg_pkg::StIdle;
      default:         st_d = ptg_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ptg_pkg::StIdle;
      deg_q <= 3'd1;
      j_q   <= '0;
      for (int i = 0; i < ptg_pkg::NumCoeff; i++) coef_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) deg_q <= cfg_wdata_i;
      if (acc_in && cmd == ptg_pkg::CmdLoad) begin
        coef_q[s_axis_tdata[3:1]] <= $signed(s_axis_tdata[19:4]);
      end
      if (acc_in) j_q <= '0;
      else if (issue) j_q <= j_q + 6'd1;
    end
  end

  // Hold the table request and advance the point
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      x_q     <= $signed(s_axis_tdata[51:20]);
      cnt_q   <= s_axis_tdata[89:84];
      step_q  <= '0;
    end else begin
      if (div_done) step_q <= quot[31:0];
      if (issue) x_q <= x_q + step_q;
    end
  end

  // Cell chain: cell k handles coefficient MaxDegree-k
  assign rows[0].vld  = issue;
  assign rows[0].x    = x_q;
  assign rows[0].acc  = '0;
  assign rows[0].ovf  = 1'b0;
  assign rows[0].last = (j_q == cnt_q);

  for (genvar k = 0; k < NCell; k++) begin : g_cell
    ptg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .use_i   (deg_q >= 3'(ptg_pkg::MaxDegree - k)),
      .coeff_i (coef_q[ptg_pkg::MaxDegree - k]),
      .row_i   (rows[k]),
      .row_o   (rows[k+1])
    );
  end

  // Final coefficient add
  assign fadd = ptg_pkg::sat_add(rows[NCell].acc, 64'(coef_q[0]) <<< 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin <= '0;
    end else begin
      fin.vld  <= rows[NCell].vld;
      fin.x    <= rows[NCell].x;
      fin.acc  <= $signed(fadd[63:0]);
      fin.ovf  <= rows[NCell].ovf | fadd[64];
      fin.last <= rows[NCell].last;
    end
  end

  // Row FIFO toward the output
  assign fwr = fin.vld;
  assign frd = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      fcount_q   <= '0;
      inflight_q <= '0;
    end else begin
      if (fwr) wp_q <= wp_q + 5'd1;
      if (frd) rp_q <= rp_q + 5'd1;
      fcount_q   <= fcount_q + 6'(fwr) - 6'(frd);
      inflight_q <= inflight_q + 6'(issue) - 6'(fwr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwr) fifo_q[wp_q] <= {fin.last, fin.ovf, fin.acc, fin.x};
  end

  assign m_axis_tvalid = (fcount_q != 6'd0);
  assign m_axis_tdata  = {7'd0, fifo_q[rp_q][96:0]};
  assign m_axis_tlast  = fifo_q[rp_q][97];

  // Assertions
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= 6'd32) else $error("row FIFO overrun");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (inflight_q == 6'd0)) else $error("input ready with rows in flight");
  a_issue_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (st_q == ptg_pkg::StGen)) else $error("row issued outside table state");

endmodule

// File: dv/tb_polynomial_table_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polynomial_table_generator: self-checking bench of the table generator
// Loads coefficients, runs tables under several degree settings and checks
// every row against a Horner predictor, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_polynomial_table_generator;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [5:0]  cnt;
    logic [31:0] stop;
    logic [31:0] start;
    logic [15:0] coeff;
    logic [2:0]  idx;
    logic        cmd;
  } beat_t;

  typedef struct {
    logic [31:0] x;
    logic [63:0] val;
    logic        ovf;
    logic        last;
    logic        typed;
  } row_exp_t;

  localparam longint unsigned CycleLimit = 2000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_wdata_i = '0;

  polynomial_table_generator DUT (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0] coeffs [ptg_pkg::NumCoeff];
  int unsigned        degree_q;
  row_exp_t           rows_q [$];
  int unsigned        errors = 0;
  int unsigned        rows_seen = 0;
  int unsigned        tables = 0;
  longint unsigned    cycles = 0;
  bit                 hold_long = 1'b0;
  int unsigned        burst_left = 0;

  // saturate a 128-bit signed value into 64 bits
  function automatic logic signed [63:0] clip64(logic signed [127:0] v, ref bit ovf);
    if (v > 128'sh7FFF_FFFF_FFFF_FFFF) begin
      ovf = 1; return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    if (v < -128'sh8000_0000_0000_0000) begin
      ovf = 1; return 64'sh8000_0000_0000_0000;
    end
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] eval_poly(logic signed [31:0] x, ref bit ovf);
    logic signed [127:0] acc, prod;
    acc = 0;
    for (int i = int'(degree_q); i >= 1; i--) begin
      acc = clip64(acc + (128'(coeffs[i]) <<< 16), ovf);
      prod = acc * 128'(x);
      acc = clip64(prod >>> 16, ovf);
    end
    return clip64(acc + (128'(coeffs[0]) <<< 16), ovf);
  endfunction

  // update state or queue the rows of one accepted beat
  task automatic predict_table(beat_t b);
    longint signed st, sp, stp, xx;
    int unsigned n;
    row_exp_t r;
    bit ovf;
    if (b.cmd == ptg_pkg::CmdLoad) begin
      coeffs[b.idx] = b.coeff;
      return;
    end
    n = b.cnt;
    st = longint'(signed'(b.start));
    sp = longint'(signed'(b.stop));
    stp = n ? (sp - st) / longint'(n) : 0;
    tables++;
    for (int j = 0; j <= n; j++) begin
      ovf = 0;
      xx = st + longint'(j) * stp;
      r.x = xx[31:0];
      r.val = eval_poly(signed'(xx[31:0]), ovf);
      r.ovf = ovf;
      r.last = (j == n);
      r.typed = 0;
      rows_q.push_back(r);
    end
  endtask

  // check output beats
  always @(posedge clk_i) begin
    row_exp_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rows_seen++;
      if (rows_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected row x=%h", $time, m_axis_tdata[31:0]);
      end else begin
        e = rows_q.pop_front();
        if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[95:32] !== e.val ||
            m_axis_tdata[96] !== e.ovf || m_axis_tlast !== e.last) begin
          errors++;
          $display("%0t: mismatch (%s) exp x=%h v=%h o=%b l=%b act x=%h v=%h o=%b l=%b",
                   $time, e.typed ? "typed" : "predicted", e.x, e.val, e.ovf, e.last,
                   m_axis_tdata[31:0], m_axis_tdata[95:32], m_axis_tdata[96],
                   m_axis_tlast);
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_polynomial_table_generator NOT OK");
      $finish;
    end
    if (hold_long) m_axis_tready <= 1'b0;
    else m_axis_tready <= (cycles[9:8] == 2'd0) ? 1'b1 : ($urandom_range(3) != 0);
  end

  task automatic write_degree(int unsigned d);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= d[2:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    degree_q = d;
  endtask

  // drop the input and wait for every expected row
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (rows_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // offer one beat, with a random gap between bursts
  task automatic send(beat_t b);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, b};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_table(b);
  endtask

  function automatic beat_t mk_load(int unsigned i, logic [15:0] v);
    beat_t b;
    b = '0; b.cmd = ptg_pkg::CmdLoad; b.idx = i[2:0]; b.coeff = v;
    b.start = $urandom; b.stop = $urandom; b.cnt = 6'($urandom);
    return b;
  endfunction

  function automatic beat_t mk_gen(logic [31:0] a, logic [31:0] z, logic [5:0] n);
    beat_t b;
    b.cmd = ptg_pkg::CmdGen; b.idx = 3'($urandom); b.coeff = 16'($urandom);
    b.start = a; b.stop = z; b.cnt = n;
    return b;
  endfunction

  beat_t directed [] = '{
    mk_gen(32'h0001_0000, 32'h0005_0000, 6'd4),
    mk_load(0, 16'h7FFF), mk_load(1, 16'h8000),
    mk_gen(32'h8000_0000, 32'h7FFF_FFFF, 6'd63),
    mk_gen(32'h0002_0000, 32'h0009_0000, 6'd0),
    mk_load(7, 16'h7FFF), mk_load(6, 16'hFFFF), mk_load(2, 16'h0003),
    mk_gen(32'h7FFF_FFFF, 32'h8000_0000, 6'd1),
    mk_gen(32'hFFFF_8000, 32'h0000_8000, 6'd5)
  };

  initial begin
    beat_t b;
    int unsigned phase_deg [] = '{7, 0, 3, 7, 2};
    for (int i = 0; i < ptg_pkg::NumCoeff; i++) coeffs[i] = 0;
    degree_q = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset all coefficients are zero: the first table reads all zero
    send(directed[0]);
    foreach (rows_q[k]) begin
      rows_q[k].val   = 64'd0;
      rows_q[k].ovf   = 1'b0;
      rows_q[k].typed = 1'b1;
    end
    for (int i = 1; i < directed.size(); i++) send(directed[i]);
    drain();

    foreach (phase_deg[p]) begin
      write_degree(phase_deg[p]);
      for (int i = 0; i < 24; i++) begin
        if ($urandom_range(2) == 0)
          b = mk_load($urandom_range(7),
                      16'($urandom_range(4) == 0 ? $urandom : $urandom_range(0, 15) - 7));
        else if ($urandom_range(4) == 0)
          b = mk_gen($urandom, $urandom, 6'($urandom));
        else
          b = mk_gen($urandom_range(0, 32'h000A_0000) - 32'h0005_0000,
                     $urandom_range(0, 32'h000A_0000) - 32'h0005_0000,
                     6'($urandom_range(0, 12)));
        if (p == 1 && i == 5) begin
          // long hold-off while the sender keeps offering a full-length table
          hold_long = 1'b1;
          fork
            begin repeat (600) @(posedge clk_i); hold_long = 1'b0; end
          join_none
          b = mk_gen(32'hFFFF_0000, 32'h0001_0000, 6'd63);
        end
        if (p == 2 && i == 10) drain();
        send(b);
      end
      drain();
    end

    $display("Covered %0d tables and %0d rows over degrees 1, 7, 0, 3, 2.", tables, rows_seen);
    if (errors == 0) begin
      $display("tb_polynomial_table_generator OK");
    end else begin
      $display("tb_polynomial_table_generator NOT OK");
    end
    $finish;
  end
endmodule

// File: sim.f
src/ptg_pkg.sv
src/ptg_div.sv
src/ptg_cell.sv
src/polynomial_table_generator.sv
dv/tb_polynomial_table_generator.sv
